FILE: hdl/tidc_pkg.sv
`timescale 1ns / 1ps

package tidc_pkg;

  localparam int unsigned MaxCapacity = 64;
  localparam int unsigned TagW        = 96;

  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_ARM    = 2'd1;
  localparam logic [1:0] KIND_FETCH  = 2'd2;

  localparam logic [1:0] CODE_ACK   = 2'd0;
  localparam logic [1:0] CODE_ENTRY = 2'd1;
  localparam logic [1:0] CODE_EMPTY = 2'd2;

  typedef logic [TagW-1:0] tag_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag_high;
    logic [63:0] tag_low;
  } req_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] out_high;
    logic [63:0] out_low;
    logic        last;
  } res_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_DUMP
  } state_e;

endpackage

FILE: hdl/tag_id_dedup_collector.sv
`timescale 1ns / 1ps

// Tag ID dedup collector.
// Command channel: req_i is taken at a rising edge with start_i high and busy_o low.
// req_i.kind selects a tag report, an arm or a fetch; unused kinds are dropped.
// Result channel: res_valid_o marks res_o for exactly one cycle; there is no stall,
// the receiver must take every result in the cycle it is shown.
// Tag report while unlocked: the cycle of acceptance compares the tag against
// every cell at once and registers a hit bit per cell; the next cycle ORs the hit bits
// and, on a miss, the first free cell of the chain stores the tag. busy_o is high then.
// A report while locked or an unused kind is dropped and leaves busy_o low.
// Arm: clears the lock; acknowledged in the cycle after acceptance.
// Fetch of n entries: the cell chain shifts towards cell 0 once per cycle and cell 0
// is streamed out through the result register, one entry per cycle, last set on the
// final one; busy_o is high during the readout. An empty table gives one marker,
// in the cycle after acceptance.
// Reset leaves the table empty and locked; reports are ignored until an arm.
module tag_id_dedup_collector #(
  parameter int unsigned CAPACITY = tidc_pkg::MaxCapacity
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  tidc_pkg::req_t req_i,
  output logic           res_valid_o,
  output tidc_pkg::res_t res_o
);

  tidc_pkg::state_e     state_q, state_d;
  logic                 locked_q, locked_d;
  logic                 res_valid_q, res_valid_d;
  tidc_pkg::res_t       res_q, res_d;
  tidc_pkg::tag_t       tag_q;
  logic                 tag_en;
  tidc_pkg::tag_t       tag_bus;
  tidc_pkg::cell_ctrl_t ctrl;
  logic                 accept;

  logic [CAPACITY:0]    chain_valid;
  tidc_pkg::tag_t       chain_tag [CAPACITY+1];
  logic [CAPACITY-1:0]  hit;

  assign busy_o = (state_q != tidc_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;

  assign tag_bus = (state_q == tidc_pkg::ST_IDLE) ? {req_i.tag_high, req_i.tag_low} : tag_q;

  assign chain_valid[CAPACITY] = 1'b0;
  assign chain_tag[CAPACITY]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tidc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .tag_i        (tag_bus),
      .prev_valid_i ((i == 0) ? 1'b1 : chain_valid[(i == 0) ? 0 : i-1]),
      .next_valid_i (chain_valid[i+1]),
      .next_tag_i   (chain_tag[i+1]),
      .valid_o      (chain_valid[i]),
      .tag_o        (chain_tag[i]),
      .hit_o        (hit[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tidc_pkg::ST_IDLE: begin
        if (accept && req_i.kind == tidc_pkg::KIND_REPORT && !locked_q) begin
          state_d = tidc_pkg::ST_INS;
        end else if (accept && req_i.kind == tidc_pkg::KIND_FETCH && chain_valid[0]) begin
          state_d = tidc_pkg::ST_DUMP;
        end
      end
      tidc_pkg::ST_INS: state_d = tidc_pkg::ST_IDLE;
      tidc_pkg::ST_DUMP: begin
        if (!chain_valid[1]) begin
          state_d = tidc_pkg::ST_IDLE;
        end
      end
      default: state_d = tidc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    tag_en      = 1'b0;
    locked_d    = locked_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      tidc_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            tidc_pkg::KIND_REPORT: begin
              if (!locked_q) begin
                ctrl.cmp = 1'b1;
                tag_en   = 1'b1;
              end
            end
            tidc_pkg::KIND_ARM: begin
              locked_d    = 1'b0;
              res_valid_d = 1'b1;
              res_d       = '{code: tidc_pkg::CODE_ACK, out_high: '0, out_low: '0,
                              last: 1'b1};
            end
            tidc_pkg::KIND_FETCH: begin
              locked_d = 1'b1;
              if (!chain_valid[0]) begin
                res_valid_d = 1'b1;
                res_d       = '{code: tidc_pkg::CODE_EMPTY, out_high: '0, out_low: '0,
                                last: 1'b1};
              end
            end
            default: ;
          endcase
        end
      end
      tidc_pkg::ST_INS: begin
        ctrl.ins = ~|hit;
      end
      tidc_pkg::ST_DUMP: begin
        ctrl.shift  = 1'b1;
        res_valid_d = 1'b1;
        res_d       = '{code: tidc_pkg::CODE_ENTRY, out_high: chain_tag[0][95:64],
                        out_low: chain_tag[0][63:0], last: !chain_valid[1]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tidc_pkg::ST_IDLE;
      locked_q    <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      locked_q    <= locked_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (tag_en) begin
      tag_q <= {req_i.tag_high, req_i.tag_low};
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // table never holds a tag twice, so at most one cell hits
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tidc_pkg::ST_INS |-> $onehot0(hit))
    else $error("more than one cell matched the reported tag");

  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tidc_pkg::ST_IDLE |=> $stable(chain_valid))
    else $error("cell occupancy changed outside insert or readout");

  a_dump_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tidc_pkg::ST_DUMP && !chain_valid[1] |=> !chain_valid[0])
    else $error("table not empty after fetch");

  a_arm_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.kind == tidc_pkg::KIND_ARM |=>
      res_valid_o && res_o.code == tidc_pkg::CODE_ACK && !locked_q)
    else $error("arm transaction not acknowledged");

endmodule

FILE: hdl/tidc_cell.sv
`timescale 1ns / 1ps

module tidc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tidc_pkg::cell_ctrl_t ctrl_i,
  input  tidc_pkg::tag_t      tag_i,
  input  logic                prev_valid_i,
  input  logic                next_valid_i,
  input  tidc_pkg::tag_t      next_tag_i,
  output logic                valid_o,
  output tidc_pkg::tag_t      tag_o,
  output logic                hit_o
);

  logic           valid_q, valid_d;
  logic           hit_q, hit_d;
  tidc_pkg::tag_t tag_q, tag_d;
  logic           take_w;

  // first free cell of the chain takes the new tag
  assign take_w = ctrl_i.ins && prev_valid_i && !valid_q;

  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    hit_d   = hit_q;
    if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      tag_d   = next_tag_i;
    end else if (take_w) begin
      valid_d = 1'b1;
      tag_d   = tag_i;
    end
    if (ctrl_i.cmp) begin
      hit_d = valid_q && (tag_q == tag_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign hit_o   = hit_q;

endmodule
